[src/superfasthash_byte_stream_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the SuperFastHash byte stream block.
// Each macro expands to a clocked concurrent assertion, or to nothing when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef SUPERFASTHASH_BYTE_STREAM_ASSERT_SVH
`define SUPERFASTHASH_BYTE_STREAM_ASSERT_SVH

`ifndef NO_ASSERTIONS
// A property that must hold at every clock edge outside reset.
`define SFH_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// A condition that must never be seen outside reset.
`define SFH_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define SFH_ASSERT(label, prop, msg)
`define SFH_ASSERT_NEVER(label, cond, msg)
`endif

`endif

[src/sfh_pkg.sv]
// ----------------------------------------------------------------------------
// SuperFastHash package
// Operation type passed from the byte front end to the hash engine, and the
// mixing functions of the hash.
// ----------------------------------------------------------------------------
package sfh_pkg;

   localparam logic [15:0] LEN_RESET = 16'd1;

   // One operation for the hash engine: an optional full group of four bytes
   // and, on the last byte of a vector, the tail and the finish request.
   typedef struct packed {
      logic        has_group;
      logic [31:0] group_word;
      logic        is_last;
      logic [1:0]  tail_count;
      logic [23:0] tail_bytes;
   } sfh_op_type;

   // Control from the front end to the hash engine.
   typedef struct packed {
      logic        restart;
      logic [31:0] start_len;
      logic [31:0] vec_len;
   } sfh_ctl_type;

   // A length of zero counts as one.
   function automatic logic [15:0] eff_len(input logic [15:0] len);
      eff_len = (len == 16'd0) ? LEN_RESET : len;
   endfunction

   // Mix one group of four bytes, read as two little-endian halves.
   function automatic logic [31:0] mix_group(input logic [31:0] h,
                                             input logic [31:0] word);
      logic [31:0] h1;
      logic [31:0] t;
      logic [31:0] h2;
      h1 = h + {16'h0, word[15:0]};
      t = ({16'h0, word[31:16]} << 11) ^ h1;
      h2 = (h1 << 16) ^ t;
      mix_group = h2 + (h2 >> 11);
   endfunction

   // Mix the trailing one, two or three bytes.
   function automatic logic [31:0] mix_tail(input logic [31:0] h,
                                            input logic [1:0]  cnt,
                                            input logic [23:0] bytes);
      logic [31:0] r;
      r = h;
      case (cnt)
         2'd3: begin
            r = r + {16'h0, bytes[15:0]};
            r = r ^ (r << 16);
            r = r ^ ({24'h0, bytes[23:16]} << 18);
            r = r + (r >> 11);
         end
         2'd2: begin
            r = r + {16'h0, bytes[15:0]};
            r = r ^ (r << 11);
            r = r + (r >> 17);
         end
         2'd1: begin
            r = r + {24'h0, bytes[7:0]};
            r = r ^ (r << 10);
            r = r + (r >> 1);
         end
         default: begin
            r = h;
         end
      endcase
      mix_tail = r;
   endfunction

   // First half of the final avalanche.
   function automatic logic [31:0] aval_first(input logic [31:0] h);
      logic [31:0] r;
      r = h ^ (h << 3);
      r = r + (r >> 5);
      aval_first = r ^ (r << 4);
   endfunction

   // Second half of the final avalanche.
   function automatic logic [31:0] aval_second(input logic [31:0] h);
      logic [31:0] r;
      r = h + (h >> 17);
      r = r ^ (r << 25);
      aval_second = r + (r >> 6);
   endfunction

endpackage

[src/sfh_fifo.sv]
// ----------------------------------------------------------------------------
// SuperFastHash queue
// Small register-based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
`include "superfasthash_byte_stream_assert.svh"

module sfh_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [AW:0] FULL_COUNT = (AW + 1)'(DEPTH);
   localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             push_ok;
   logic             pop_ok;

   assign full     = (count_ff == FULL_COUNT);
   assign empty    = (count_ff == '0);
   assign push_ok  = push && !full;
   assign pop_ok   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage write.
   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `SFH_ASSERT(a_fifo_count_bound, count_ff <= FULL_COUNT, "queue occupancy beyond depth")
   `SFH_ASSERT(a_fifo_push_fills, (push_ok && !pop_ok) |=> !empty, "queue empty after a push")

endmodule

[src/sfh_front.sv]
// ----------------------------------------------------------------------------
// SuperFastHash front end
// Takes bytes, assembles groups of four and marks the last byte of each
// vector; holds the length register.
// ----------------------------------------------------------------------------
`include "superfasthash_byte_stream_assert.svh"

module sfh_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  logic [7:0]           req_data_byte,
   output logic                 req_full,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [15:0]          csr_message_length,
   input  logic                 op_full,
   output logic                 op_push,
   output sfh_pkg::sfh_op_type  op_data,
   output sfh_pkg::sfh_ctl_type ctl
);

   import sfh_pkg::*;

   logic [15:0] len_ff, len_in;
   logic [15:0] pos_ff, pos_in;
   logic [23:0] pend_ff, pend_in;
   logic [15:0] len_eff;
   logic [15:0] pos_next;
   logic [1:0]  slot;
   logic [23:0] pend_merge;
   logic        accept;
   logic        csr_write;
   logic        is_last;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign req_full  = op_full;
   assign accept    = req_push && !op_full;

   assign len_eff  = eff_len(len_ff);
   assign slot     = pos_ff[1:0];
   assign pos_next = pos_ff + 16'd1;
   assign is_last  = (pos_next >= len_eff);

   // Place the byte into the unfinished group.
   always_comb begin
      case (slot)
         2'd0: pend_merge = {16'h0, req_data_byte};
         2'd1: pend_merge = {8'h0, req_data_byte, pend_ff[7:0]};
         2'd2: pend_merge = {req_data_byte, pend_ff[15:0]};
         default: pend_merge = 24'h0;
      endcase
   end

   // Operation for the hash engine.
   always_comb begin
      op_data.has_group  = (slot == 2'd3);
      op_data.group_word = {req_data_byte, pend_ff};
      op_data.is_last    = is_last;
      op_data.tail_count = pos_next[1:0];
      op_data.tail_bytes = pend_merge;
      op_push = accept && ((slot == 2'd3) || is_last);
   end

   // Control toward the engine: restart on a length write.
   always_comb begin
      ctl.restart   = csr_write;
      ctl.start_len = {16'h0, eff_len(csr_message_length)};
      ctl.vec_len   = {16'h0, len_eff};
   end

   // Position, partial group and length update.
   always_comb begin
      len_in  = len_ff;
      pos_in  = pos_ff;
      pend_in = pend_ff;
      if (csr_write) begin
         len_in  = csr_message_length;
         pos_in  = '0;
         pend_in = '0;
      end else if (accept) begin
         if (is_last) begin
            pos_in  = '0;
            pend_in = '0;
         end else begin
            pos_in  = pos_next;
            pend_in = pend_merge;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= LEN_RESET;
         pos_ff  <= '0;
         pend_ff <= '0;
      end else begin
         len_ff  <= len_in;
         pos_ff  <= pos_in;
         pend_ff <= pend_in;
      end
   end

   `SFH_ASSERT(a_front_pos_range, pos_ff < len_eff, "byte position reached the vector length")

endmodule

[src/sfh_back.sv]
// ----------------------------------------------------------------------------
// SuperFastHash engine
// Runs the group mixing on the accumulator and finishes each vector through
// a three-stage tail and avalanche pipeline.
// ----------------------------------------------------------------------------
`include "superfasthash_byte_stream_assert.svh"

module sfh_back (
   input  logic                 clock,
   input  logic                 reset,
   input  sfh_pkg::sfh_ctl_type ctl,
   input  logic                 op_empty,
   input  sfh_pkg::sfh_op_type  op_data,
   output logic                 op_pop,
   input  logic                 rsp_full,
   output logic                 rsp_push,
   output logic [31:0]          rsp_data
);

   import sfh_pkg::*;

   logic [31:0] acc_ff, acc_in;
   logic        s1_vld_ff, s1_vld_in;
   logic [31:0] s1_h_ff, s1_h_in;
   logic [1:0]  s1_cnt_ff, s1_cnt_in;
   logic [23:0] s1_tail_ff, s1_tail_in;
   logic        s2_vld_ff, s2_vld_in;
   logic [31:0] s2_h_ff, s2_h_in;
   logic        s3_vld_ff, s3_vld_in;
   logic [31:0] s3_h_ff, s3_h_in;
   logic        adv;
   logic        take;
   logic [31:0] h_grp;

   // The whole pipeline moves when the result queue has room.
   assign adv    = !rsp_full;
   assign take   = adv && !op_empty;
   assign op_pop = take;

   assign h_grp = op_data.has_group ? mix_group(acc_ff, op_data.group_word) : acc_ff;

   // Accumulator: mix groups, restart after the last byte or a length write.
   always_comb begin
      acc_in = acc_ff;
      if (ctl.restart) begin
         acc_in = ctl.start_len;
      end else if (take) begin
         acc_in = op_data.is_last ? ctl.vec_len : h_grp;
      end
   end

   // Finishing pipeline.
   always_comb begin
      s1_vld_in  = take && op_data.is_last;
      s1_h_in    = h_grp;
      s1_cnt_in  = op_data.tail_count;
      s1_tail_in = op_data.tail_bytes;
      s2_vld_in  = s1_vld_ff;
      s2_h_in    = mix_tail(s1_h_ff, s1_cnt_ff, s1_tail_ff);
      s3_vld_in  = s2_vld_ff;
      s3_h_in    = aval_first(s2_h_ff);
   end

   assign rsp_push = adv && s3_vld_ff;
   assign rsp_data = aval_second(s3_h_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= {16'h0, LEN_RESET};
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         if (adv) begin
            s1_vld_ff <= s1_vld_in;
            s2_vld_ff <= s2_vld_in;
            s3_vld_ff <= s3_vld_in;
         end
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_h_ff    <= s1_h_in;
         s1_cnt_ff  <= s1_cnt_in;
         s1_tail_ff <= s1_tail_in;
         s2_h_ff    <= s2_h_in;
         s3_h_ff    <= s3_h_in;
      end
   end

   `SFH_ASSERT(a_back_restart, (take && op_data.is_last && !ctl.restart) |=> (acc_ff == $past(ctl.vec_len)), "accumulator not restarted after the last byte")

endmodule

[src/superfasthash_byte_stream.sv]
// A result passes through the operation queue, the finishing stages and the result queue.
// Throughput: one byte per cycle while req_full is low; the engine takes one operation per cycle.
// The result queue being full stalls the engine; the operation queue then fills and asserts full.
// Reset is synchronous and active high; the length resets to one and both queues empty.
// ----------------------------------------------------------------------------
// SuperFastHash byte stream
// Hashes vectors of a configured byte length with the 32-bit SuperFastHash,
// one byte per transaction, one hash per vector.
// ----------------------------------------------------------------------------
module superfasthash_byte_stream #(
   parameter int OP_DEPTH  = 4,
   parameter int RSP_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic [7:0]  req_data_byte,
   output logic        req_full,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_hash_value,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_message_length
);

   import sfh_pkg::*;

   sfh_op_type  op_in;
   sfh_op_type  op_out;
   sfh_ctl_type ctl;
   logic        op_push;
   logic        op_full;
   logic        op_empty;
   logic        op_pop;
   logic        rsp_push;
   logic        rsp_full;
   logic [31:0] rsp_data;

   // Byte front end.
   sfh_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_data_byte      (req_data_byte),
      .req_full           (req_full),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_message_length (csr_message_length),
      .op_full            (op_full),
      .op_push            (op_push),
      .op_data            (op_in),
      .ctl                (ctl)
   );

   // Queue of operations between the front end and the engine.
   sfh_fifo #(
      .WIDTH ($bits(sfh_op_type)),
      .DEPTH (OP_DEPTH)
   ) u_op_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (op_push),
      .push_data (op_in),
      .full      (op_full),
      .pop       (op_pop),
      .pop_data  (op_out),
      .empty     (op_empty)
   );

   // Hash engine.
   sfh_back u_back (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .op_empty (op_empty),
      .op_data  (op_out),
      .op_pop   (op_pop),
      .rsp_full (rsp_full),
      .rsp_push (rsp_push),
      .rsp_data (rsp_data)
   );

   // Result queue toward the consumer.
   sfh_fifo #(
      .WIDTH (32),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_data),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_hash_value),
      .empty     (rsp_empty)
   );

endmodule
